// ===== src/dtpc_pkg.sv =====
// Shared types and constants for the depth to point cloud block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package dtpc_pkg;

	localparam int DTPC_MAX_DIM  = 4096;
	localparam int DTPC_QDEPTH   = 2;
	localparam int DEPTH_W       = 24;
	localparam int DIM_REG_W     = 13;
	localparam int FOCAL_W       = 16;
	localparam int STEP_W        = 8;
	localparam int CFG_DATA_W    = 16;
	localparam int PROD_W        = 34;
	localparam int Y_W           = 18;
	localparam int COORD_W       = 32;
	localparam int INDEX_W       = 24;
	localparam int FRAC_BITS     = 16;
	localparam logic [PROD_W-1:0] MM_PER_METRE = PROD_W'(1000);

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_FOCAL  = 2'd2,
		REG_STEP   = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_MUL,
		B_DIV,
		B_OUT
	} back_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} dtpc_qstat_t;

endpackage

// ===== src/dtpc_fifo.sv =====
// Short register queue between the pixel front end and the projection back end.
// Depends on dtpc_pkg for the status struct.
`timescale 1ns / 1ps

module dtpc_fifo import dtpc_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = DTPC_QDEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output dtpc_qstat_t      status
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CNTW-1:0]  count_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		if (p == PW'(DEPTH - 1)) begin
			return '0;
		end
		return p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= ptr_next(wptr_q);
			end
			if (pop) begin
				rptr_q <= ptr_next(rptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

	assign rdata        = entry_q[rptr_q];
	assign status.full  = (count_q == CNTW'(DEPTH));
	assign status.empty = (count_q == '0);

endmodule

// ===== src/dtpc_front.sv =====
// Front end: pixel counters, subsample countdown and per-point setup terms.
// Depends on dtpc_pkg; feeds dtpc_fifo.
`timescale 1ns / 1ps

module dtpc_front import dtpc_pkg::*; #(
	parameter int MAX_DIM = DTPC_MAX_DIM,
	parameter int CW      = $clog2(MAX_DIM),
	parameter int AW      = CW + 1,
	parameter int ITEM_W  = 2 * (AW + 1) + PROD_W + INDEX_W + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [DEPTH_W-1:0]   depth,
	input  logic [DIM_REG_W-1:0] width_reg,
	input  logic [DIM_REG_W-1:0] height_reg,
	input  logic [STEP_W-1:0]    step_reg,
	output logic                 push,
	output logic [ITEM_W-1:0]    item
);

	localparam int IXW = CW + AW;

	logic [CW-1:0]     col_q, row_q;
	logic [STEP_W-1:0] cd_q;
	logic [AW-1:0]     w, h;
	logic [STEP_W-1:0] step;
	logic              row_end, last, emit;
	logic [AW:0]       sdx, sdz;
	logic              neg_dx, neg_dz;
	logic [AW-1:0]     abs_dx, abs_dz;
	logic [PROD_W-1:0] prod;
	logic [IXW-1:0]    idx_full;

	function automatic logic [AW-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
		if (v == '0) begin
			return AW'(1);
		end
		if (32'(v) > MAX_DIM) begin
			return AW'(MAX_DIM);
		end
		return AW'(v);
	endfunction

	always_comb begin
		w    = clamp_dim(width_reg);
		h    = clamp_dim(height_reg);
		step = (step_reg == '0) ? STEP_W'(1) : step_reg;
		row_end = (AW'(col_q) + AW'(1)) >= w;
		last    = row_end && ((AW'(row_q) + AW'(1)) >= h);
		emit    = (cd_q == '0);
		sdx = $signed({2'b00, col_q}) - $signed({1'b0, w >> 1});
		sdz = $signed({1'b0, h >> 1}) - $signed({2'b00, row_q});
		neg_dx = sdx[AW];
		neg_dz = sdz[AW];
		abs_dx = neg_dx ? AW'(-sdx) : sdx[AW-1:0];
		abs_dz = neg_dz ? AW'(-sdz) : sdz[AW-1:0];
		prod     = PROD_W'(depth) * MM_PER_METRE;
		idx_full = IXW'(row_q) * IXW'(w) + IXW'(col_q);
	end

	assign push = take && emit;
	assign item = {neg_dx, abs_dx, neg_dz, abs_dz, prod, INDEX_W'(idx_full), last};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cd_q  <= '0;
		end else if (take) begin
			if (last) begin
				col_q <= '0;
				row_q <= '0;
				cd_q  <= '0;
			end else begin
				cd_q <= emit ? step - STEP_W'(1) : cd_q - STEP_W'(1);
				if (row_end) begin
					col_q <= '0;
					row_q <= row_q + CW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

endmodule

// ===== src/dtpc_back.sv =====
// Back end: scales offsets by depth, divides by focal length bit by bit, saturates.
// Depends on dtpc_pkg; drains dtpc_fifo and drives the result channel.
`timescale 1ns / 1ps

module dtpc_back import dtpc_pkg::*; #(
	parameter int MAX_DIM = DTPC_MAX_DIM,
	parameter int CW      = $clog2(MAX_DIM),
	parameter int AW      = CW + 1,
	parameter int ITEM_W  = 2 * (AW + 1) + PROD_W + INDEX_W + 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [ITEM_W-1:0]   item,
	input  logic                q_empty,
	output logic                pop,
	input  logic [FOCAL_W-1:0]  focal_reg,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [COORD_W-1:0]  point_x_mm,
	output logic [Y_W-1:0]      point_y_mm,
	output logic [COORD_W-1:0]  point_z_mm,
	output logic [INDEX_W-1:0]  pixel_index,
	output logic                frame_last
);

	localparam int MW = AW + PROD_W;
	localparam int NW = MW - FRAC_BITS;
	localparam int KW = $clog2(NW + 1);

	back_state_t state_q, state_d;

	logic              neg_dx_q, neg_dz_q, last_q;
	logic [AW-1:0]     abs_dx_q, abs_dz_q;
	logic [PROD_W-1:0] prod_q;
	logic [INDEX_W-1:0] idx_q;
	logic [NW-1:0]     qx_q, qz_q;
	logic [FOCAL_W-1:0] rx_q, rz_q;
	logic [KW-1:0]     k_q;
	logic [FOCAL_W-1:0] f;
	logic [MW-1:0]     mx, mz;
	logic [FOCAL_W:0]  tx, tz;
	logic              gx, gz;
	logic              div_done;

	function automatic logic [COORD_W-1:0] sat(input logic [NW-1:0] q, input logic neg);
		logic [63:0] qe;
		qe = 64'(q);
		if (!neg) begin
			return (qe > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : qe[31:0];
		end
		return (qe > 64'h8000_0000) ? 32'h8000_0000 : (~qe[31:0] + 32'd1);
	endfunction

	always_comb begin
		f  = (focal_reg == '0) ? FOCAL_W'(1) : focal_reg;
		mx = MW'(abs_dx_q) * MW'(prod_q);
		mz = MW'(abs_dz_q) * MW'(prod_q);
		tx = {rx_q, qx_q[NW-1]};
		tz = {rz_q, qz_q[NW-1]};
		gx = tx >= {1'b0, f};
		gz = tz >= {1'b0, f};
		div_done = (k_q == KW'(NW - 1));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: if (!q_empty) state_d = B_MUL;
			B_MUL:  state_d = B_DIV;
			B_DIV:  if (div_done) state_d = B_OUT;
			B_OUT:  if (!out_stall) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			B_IDLE:  pop = !q_empty;
			B_OUT:   out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath: load, multiply, then one quotient bit per cycle for both axes
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					{neg_dx_q, abs_dx_q, neg_dz_q, abs_dz_q, prod_q, idx_q, last_q} <= item;
				end
			end
			B_MUL: begin
				qx_q <= mx[MW-1:FRAC_BITS];
				qz_q <= mz[MW-1:FRAC_BITS];
				rx_q <= '0;
				rz_q <= '0;
				k_q  <= '0;
			end
			B_DIV: begin
				rx_q <= gx ? FOCAL_W'(tx - {1'b0, f}) : tx[FOCAL_W-1:0];
				rz_q <= gz ? FOCAL_W'(tz - {1'b0, f}) : tz[FOCAL_W-1:0];
				qx_q <= {qx_q[NW-2:0], gx};
				qz_q <= {qz_q[NW-2:0], gz};
				k_q  <= k_q + KW'(1);
			end
			default: ;
		endcase
	end

	assign point_x_mm  = sat(qx_q, neg_dx_q);
	assign point_z_mm  = sat(qz_q, neg_dz_q);
	assign point_y_mm  = prod_q[FRAC_BITS +: Y_W];
	assign pixel_index = idx_q;
	assign frame_last  = last_q;

endmodule

// ===== src/depth_to_point_cloud.sv =====
// Top level of the depth to point cloud block: config registers, front, queue, back.
// Depends on dtpc_pkg, dtpc_front, dtpc_fifo and dtpc_back.
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_stall    depth_metres
//  out      source     out_valid / out_stall  point_x_mm, point_y_mm, point_z_mm,
//                                             pixel_index, frame_last
//  cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A skipped pixel never enters the queue. An emitted point occupies the back end while
// the bit-serial divider by focal length forms NW = clog2(MAX_DIM) + 19 quotient bits
// (31 at the default); the two-entry queue lets the front take pixels meanwhile.
// Reset clears counters, queue and state; registers return to 640, 480, 667, 1.
// in_stall rises only while the queue is full; a stalled result holds the back end.
`timescale 1ns / 1ps

module depth_to_point_cloud import dtpc_pkg::*; #(
	parameter int MAX_DIM = DTPC_MAX_DIM
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [DEPTH_W-1:0]    depth_metres,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [COORD_W-1:0] point_x_mm,
	output logic [Y_W-1:0]        point_y_mm,
	output logic signed [COORD_W-1:0] point_z_mm,
	output logic [INDEX_W-1:0]    pixel_index,
	output logic                  frame_last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CW     = $clog2(MAX_DIM);
	localparam int AW     = CW + 1;
	localparam int ITEM_W = 2 * (AW + 1) + PROD_W + INDEX_W + 1;

	logic [DIM_REG_W-1:0] width_q, height_q;
	logic [FOCAL_W-1:0]   focal_q;
	logic [STEP_W-1:0]    step_q;
	logic                 take, push, pop;
	logic [ITEM_W-1:0]    item_w, item_r;
	dtpc_qstat_t          qstat;
	logic [COORD_W-1:0]   px, pz;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_REG_W'(640);
			height_q <= DIM_REG_W'(480);
			focal_q  <= FOCAL_W'(667);
			step_q   <= STEP_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_WIDTH:  width_q  <= cfg_data[DIM_REG_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[DIM_REG_W-1:0];
				REG_FOCAL:  focal_q  <= cfg_data;
				REG_STEP:   step_q   <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall = qstat.full;
	assign take     = in_valid && !in_stall;

	dtpc_front #(.MAX_DIM(MAX_DIM), .CW(CW), .AW(AW), .ITEM_W(ITEM_W)) u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .depth(depth_metres),
		.width_reg(width_q), .height_reg(height_q), .step_reg(step_q),
		.push(push), .item(item_w)
	);

	dtpc_fifo #(.WIDTH(ITEM_W), .DEPTH(DTPC_QDEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(item_w),
		.pop(pop), .rdata(item_r), .status(qstat)
	);

	dtpc_back #(.MAX_DIM(MAX_DIM), .CW(CW), .AW(AW), .ITEM_W(ITEM_W)) u_back (
		.clk(clk), .arst_n(arst_n), .item(item_r), .q_empty(qstat.empty), .pop(pop),
		.focal_reg(focal_q), .out_valid(out_valid), .out_stall(out_stall),
		.point_x_mm(px), .point_y_mm(point_y_mm), .point_z_mm(pz),
		.pixel_index(pixel_index), .frame_last(frame_last)
	);

	assign point_x_mm = $signed(px);
	assign point_z_mm = $signed(pz);

`ifndef NO_ASSERTIONS
	a_q_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.full && qstat.empty))
		else $error("queue reports full and empty together");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("back end took from an empty queue");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> !out_valid)
		else $error("result repeated after transfer");
`endif

endmodule

// ===== bench/depth_to_point_cloud_chk.sv =====
// Checker for the depth to point cloud block: watches the pixel, point and
// register channels, predicts each point and compares. Depends on dtpc_pkg.
`timescale 1ns / 1ps

module depth_to_point_cloud_chk import dtpc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [DEPTH_W-1:0]        depth_metres,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic signed [COORD_W-1:0] point_x_mm,
	input  logic [Y_W-1:0]            point_y_mm,
	input  logic signed [COORD_W-1:0] point_z_mm,
	input  logic [INDEX_W-1:0]        pixel_index,
	input  logic                      frame_last,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	output int                        fail_count,
	output int                        pending,
	output int                        points_seen
);

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic [Y_W-1:0]            y;
		logic signed [COORD_W-1:0] z;
		logic [INDEX_W-1:0]        idx;
		logic                      last;
	} point_t;

	point_t points_due[$];
	logic [DIM_REG_W-1:0] width_reg, height_reg;
	logic [FOCAL_W-1:0]   focal_reg;
	logic [STEP_W-1:0]    step_reg;
	int unsigned col_cnt, row_cnt, skip_left;

	function automatic int unsigned dim_of(logic [DIM_REG_W-1:0] v);
		if (v == 0) return 1;
		if (v > DTPC_MAX_DIM) return DTPC_MAX_DIM;
		return v;
	endfunction

	function automatic logic signed [COORD_W-1:0] project(longint off, longint d,
			longint f);
		longint q;
		q = (off * (d * 1000)) / (f <<< 16);
		if (q > 64'sd2147483647) q = 64'sd2147483647;
		if (q < -64'sd2147483648) q = -64'sd2147483648;
		return q[COORD_W-1:0];
	endfunction

	task automatic predict_pixel(logic [DEPTH_W-1:0] d);
		int unsigned w, h, f, st;
		logic row_end, last;
		point_t p;
		w = dim_of(width_reg);
		h = dim_of(height_reg);
		f = (focal_reg == 0) ? 1 : focal_reg;
		st = (step_reg == 0) ? 1 : step_reg;
		row_end = (col_cnt + 1) >= w;
		last = row_end && (row_cnt + 1) >= h;
		if (skip_left == 0) begin
			p.x = project(longint'(col_cnt) - longint'(w / 2), d, f);
			p.z = project(longint'(h / 2) - longint'(row_cnt), d, f);
			p.y = Y_W'((longint'(d) * 1000) >> 16);
			p.idx = INDEX_W'(row_cnt * w + col_cnt);
			p.last = last;
			points_due.push_back(p);
			skip_left = st - 1;
		end else
			skip_left--;
		if (last) begin
			col_cnt = 0; row_cnt = 0; skip_left = 0;
		end else if (row_end) begin
			col_cnt = 0; row_cnt++;
		end else
			col_cnt++;
	endtask

	task automatic compare_point();
		point_t e;
		if (points_due.size() == 0) begin
			$display("%0t: unexpected point idx %0d", $time, pixel_index);
			fail_count++;
			return;
		end
		e = points_due.pop_front();
		if (e.x !== point_x_mm) begin
			$display("%0t: x exp %0d got %0d", $time, e.x, point_x_mm); fail_count++;
		end
		if (e.y !== point_y_mm) begin
			$display("%0t: y exp %0d got %0d", $time, e.y, point_y_mm); fail_count++;
		end
		if (e.z !== point_z_mm) begin
			$display("%0t: z exp %0d got %0d", $time, e.z, point_z_mm); fail_count++;
		end
		if (e.idx !== pixel_index) begin
			$display("%0t: index exp %0d got %0d", $time, e.idx, pixel_index);
			fail_count++;
		end
		if (e.last !== frame_last) begin
			$display("%0t: frame_last exp %0b got %0b", $time, e.last, frame_last);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = 640; height_reg = 480; focal_reg = 667; step_reg = 1;
			col_cnt = 0; row_cnt = 0; skip_left = 0;
			points_due.delete();
			fail_count = 0;
			points_seen = 0;
		end else begin
			if (out_valid && !out_stall) begin
				compare_point();
				points_seen++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_WIDTH:  width_reg = cfg_data[DIM_REG_W-1:0];
					REG_HEIGHT: height_reg = cfg_data[DIM_REG_W-1:0];
					REG_FOCAL:  focal_reg = cfg_data[FOCAL_W-1:0];
					REG_STEP:   step_reg = cfg_data[STEP_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_pixel(depth_metres);
		end
		pending = points_due.size();
	end

endmodule

// ===== bench/depth_to_point_cloud_tb.sv =====
// Testbench top for depth_to_point_cloud: clock, reset, pixel and register
// stimulus, and the verdict. Depends on dtpc_pkg and depth_to_point_cloud_chk.
`timescale 1ns / 1ps

module depth_to_point_cloud_tb;
	import dtpc_pkg::*;

	localparam int WATCHDOG = 20000;
	localparam int TAIL     = 200;

	logic clk, arst_n;
	logic in_valid, in_stall;
	logic [DEPTH_W-1:0] depth_metres;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [COORD_W-1:0] point_x_mm, point_z_mm;
	logic [Y_W-1:0] point_y_mm;
	logic [INDEX_W-1:0] pixel_index;
	logic frame_last;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int fail_count, pending, points_seen;
	int idle_cycles = 0;
	int px_sent;
	bit calm;

	depth_to_point_cloud u_top (.*);

	depth_to_point_cloud_chk u_chk (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// receiver stalls at random except during the calm stretch
	always @(negedge clk)
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 30);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("watchdog expired");
			$display("depth_to_point_cloud test failed");
			$finish;
		end
	end

	// valid is left high; setup drops it after the last write
	task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
		cfg_valid <= 1; cfg_index <= r; cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// valid is left high after the transfer; an idle gap or drain drops it
	task automatic send_pixel(logic [DEPTH_W-1:0] d);
		while (!calm && $urandom_range(99) < 30) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1; depth_metres <= d;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		px_sent++;
	endtask

	// hold until every point has left, then let the back end drain
	task automatic drain();
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (TAIL) @(negedge clk);
	endtask

	task automatic setup(int w, int h, int f, int st);
		drain();
		write_reg(REG_WIDTH, CFG_DATA_W'(w));
		write_reg(REG_HEIGHT, CFG_DATA_W'(h));
		write_reg(REG_FOCAL, CFG_DATA_W'(f));
		write_reg(REG_STEP, CFG_DATA_W'(st));
		cfg_valid <= 0;
	endtask

	function automatic logic [DEPTH_W-1:0] rand_depth();
		case ($urandom_range(3))
			0: return '0;
			1: return 24'hFFFFFF;
			default: return DEPTH_W'($urandom);
		endcase
	endfunction

	initial begin
		int w, h;
		in_valid = 0; depth_metres = 0;
		cfg_valid = 0; cfg_index = REG_WIDTH; cfg_data = 0;
		px_sent = 0; calm = 0;
		arst_n = 0;
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: reset values, extreme depths, start of frame
		send_pixel('0);
		send_pixel(24'hFFFFFF);
		send_pixel(24'h010000);
		// tiny frame, focal one: largest depths and last pixel flag
		setup(2, 2, 1, 1);
		repeat (4) send_pixel(24'hFFFFFF);
		// zero sizes, focal and step taken as one
		setup(0, 0, 0, 0);
		repeat (3) send_pixel(24'hABCDEF);
		// largest sizes, largest focal and step: a corner far from centre
		setup(8191, 4096, 65535, 255);
		repeat (6) send_pixel(24'hFFFFFF);
		// width three, step two: middle pixel skipped, frame_last still on the last pixel
		setup(3, 1, 5, 2);
		repeat (6) send_pixel(DEPTH_W'($urandom));

		// random phases of small frames
		for (int ph = 0; ph < 24; ph++) begin
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 8);
			setup(($urandom_range(9) == 0) ? $urandom_range(8191) : w,
				($urandom_range(9) == 0) ? $urandom_range(8191) : h,
				($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(1, 900),
				($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(1, 4));
			calm = (ph == 10);
			repeat (70) send_pixel(rand_depth());
			calm = 0;
		end
		setup(640, 480, 667, 1);
		repeat (30) send_pixel(rand_depth());
		drain();

		$display("%0d pixels sent, %0d points checked over 29 register settings",
			px_sent, points_seen);
		if (fail_count == 0 && pending == 0)
			$display("depth_to_point_cloud test passed");
		else
			$display("depth_to_point_cloud test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/dtpc_pkg.sv
src/dtpc_fifo.sv
src/dtpc_front.sv
src/dtpc_back.sv
src/depth_to_point_cloud.sv
bench/depth_to_point_cloud_chk.sv
bench/depth_to_point_cloud_tb.sv
